// ----- rtl/ufrc_pkg.sv -----
// shared types and constants for the union-find engine
package ufrc_pkg;

   localparam int IDX_W       = 9;
   localparam int CNT_W       = 10;
   localparam int RANK_W      = 4;
   localparam int RANK_MAX    = 15;
   localparam int RESET_COUNT = 512;

   typedef enum logic [1:0] {
      KIND_QUERY   = 2'd0,
      KIND_UNION   = 2'd1,
      KIND_RESTART = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_CLEAR,
      S_WALK,
      S_COMP,
      S_LINK,
      S_BUMP,
      S_DONE
   } state_type;

endpackage

// ----- rtl/union_find_rank_compress.sv -----
// union-find engine with union by rank and path compression over one table memory
// query or union: S_WALK and S_COMP find and compress the first path, then the second,
// then S_LINK, plus S_BUMP when a union raises a rank; bad index: straight to S_DONE
// restart: sweeps the clamped element_count entries of the table, one entry a cycle
// one item at a time; a result may wait in the output register
// reset sweeps min(512, MAX_ELEMENTS) entries before the first item is accepted
module union_find_rank_compress
   import ufrc_pkg::*;
#(
   parameter int MAX_ELEMENTS = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_kind,
   input  logic [IDX_W-1:0] req_first_index,
   input  logic [IDX_W-1:0] req_second_index,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_same_before,
   output logic [IDX_W-1:0] rsp_first_root,
   output logic [CNT_W-1:0] rsp_live_sets,
   output logic             rsp_index_error,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CNT_W-1:0] csr_element_count
);

   localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int WORD_W = RANK_W + ADDR_W;
   localparam int RESET_ACTIVE = (RESET_COUNT > MAX_ELEMENTS) ? MAX_ELEMENTS : RESET_COUNT;

   // table memory: {rank, parent}
   logic [WORD_W-1:0] table_mem [MAX_ELEMENTS];
   logic [WORD_W-1:0] rdata_ff;
   logic [ADDR_W-1:0] raddr;
   logic              wen;
   logic [ADDR_W-1:0] waddr;
   logic [WORD_W-1:0] wdata;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  elem_count_ff, elem_count_in;
   logic [CNT_W-1:0]  active_ff, active_in;
   logic [CNT_W-1:0]  sets_ff, sets_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [1:0]        kind_ff, kind_in;
   logic [ADDR_W-1:0] x_ff, x_in;
   logic [ADDR_W-1:0] y_ff, y_in;
   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic [ADDR_W-1:0] root_ff, root_in;
   logic [RANK_W-1:0] rank_root_ff, rank_root_in;
   logic [ADDR_W-1:0] a_ff, a_in;
   logic [RANK_W-1:0] rank_a_ff, rank_a_in;
   logic              phase_b_ff, phase_b_in;
   logic              res_same_ff, res_same_in;
   logic [IDX_W-1:0]  res_root_ff, res_root_in;
   logic              res_err_ff, res_err_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_same_ff, out_same_in;
   logic [IDX_W-1:0]  out_root_ff, out_root_in;
   logic [CNT_W-1:0]  out_live_ff, out_live_in;
   logic              out_err_ff, out_err_in;

   logic [ADDR_W-1:0] rd_parent;
   logic [RANK_W-1:0] rd_rank;
   logic [CNT_W-1:0]  clamped;
   logic              accept;
   logic              bad_index;

   assign rd_parent = rdata_ff[ADDR_W-1:0];
   assign rd_rank   = rdata_ff[WORD_W-1:ADDR_W];

   assign req_stall       = (state_ff != S_IDLE);
   assign accept          = req_valid && !req_stall;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = out_valid_ff;
   assign rsp_same_before = out_same_ff;
   assign rsp_first_root  = out_root_ff;
   assign rsp_live_sets   = out_live_ff;
   assign rsp_index_error = out_err_ff;

   always_comb begin
      if (32'(elem_count_ff) > MAX_ELEMENTS) begin
         clamped = CNT_W'(MAX_ELEMENTS);
      end else begin
         clamped = elem_count_ff;
      end
   end

   assign bad_index = ({1'b0, req_first_index} >= active_ff)
                   || ({1'b0, req_second_index} >= active_ff);

   // table memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wen) begin
         table_mem[waddr] <= wdata;
      end
      rdata_ff <= table_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         elem_count_ff <= CNT_W'(RESET_COUNT);
         active_ff     <= CNT_W'(RESET_ACTIVE);
         sets_ff       <= CNT_W'(RESET_ACTIVE);
         clr_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         elem_count_ff <= elem_count_in;
         active_ff     <= active_in;
         sets_ff       <= sets_in;
         clr_ff        <= clr_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      cur_ff       <= cur_in;
      root_ff      <= root_in;
      rank_root_ff <= rank_root_in;
      a_ff         <= a_in;
      rank_a_ff    <= rank_a_in;
      phase_b_ff   <= phase_b_in;
      res_same_ff  <= res_same_in;
      res_root_ff  <= res_root_in;
      res_err_ff   <= res_err_in;
      out_same_ff  <= out_same_in;
      out_root_ff  <= out_root_in;
      out_live_ff  <= out_live_in;
      out_err_ff   <= out_err_in;
   end

   always_comb begin
      state_in      = state_ff;
      elem_count_in = elem_count_ff;
      active_in     = active_ff;
      sets_in       = sets_ff;
      clr_in        = clr_ff;
      kind_in       = kind_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      cur_in        = cur_ff;
      root_in       = root_ff;
      rank_root_in  = rank_root_ff;
      a_in          = a_ff;
      rank_a_in     = rank_a_ff;
      phase_b_in    = phase_b_ff;
      res_same_in   = res_same_ff;
      res_root_in   = res_root_ff;
      res_err_in    = res_err_ff;
      out_valid_in  = out_valid_ff;
      out_same_in   = out_same_ff;
      out_root_in   = out_root_ff;
      out_live_in   = out_live_ff;
      out_err_in    = out_err_ff;
      raddr         = cur_ff;
      wen           = 1'b0;
      waddr         = cur_ff;
      wdata         = rdata_ff;

      if (csr_valid && csr_ready) begin
         elem_count_in = csr_element_count;
      end
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_INIT, S_CLEAR: begin
            wen    = 1'b1;
            waddr  = clr_ff;
            wdata  = {RANK_W'(0), clr_ff};
            clr_in = clr_ff + ADDR_W'(1);
            if (32'(clr_ff) + 32'd1 >= 32'(active_ff)) begin
               clr_in   = '0;
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end
         end
         S_IDLE: begin
            raddr = ADDR_W'(req_first_index);
            if (accept) begin
               kind_in     = req_kind;
               x_in        = ADDR_W'(req_first_index);
               y_in        = ADDR_W'(req_second_index);
               cur_in      = ADDR_W'(req_first_index);
               phase_b_in  = 1'b0;
               res_same_in = 1'b0;
               res_err_in  = 1'b0;
               res_root_in = '0;
               if (req_kind == KIND_RESTART) begin
                  active_in = clamped;
                  sets_in   = clamped;
                  clr_in    = '0;
                  if ({1'b0, req_first_index} < clamped) begin
                     res_root_in = req_first_index;
                  end
                  state_in = (clamped == '0) ? S_DONE : S_CLEAR;
               end else if (bad_index) begin
                  res_err_in = 1'b1;
                  state_in   = S_DONE;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (rd_parent == cur_ff) begin
               root_in      = cur_ff;
               rank_root_in = rd_rank;
               raddr        = phase_b_ff ? y_ff : x_ff;
               cur_in       = phase_b_ff ? y_ff : x_ff;
               state_in     = S_COMP;
            end else begin
               raddr  = rd_parent;
               cur_in = rd_parent;
            end
         end
         S_COMP: begin
            if (cur_ff == root_ff) begin
               if (phase_b_ff) begin
                  state_in = S_LINK;
               end else begin
                  a_in       = root_ff;
                  rank_a_in  = rank_root_ff;
                  phase_b_in = 1'b1;
                  raddr      = y_ff;
                  cur_in     = y_ff;
                  state_in   = S_WALK;
               end
            end else begin
               // point the walked entry straight at the root
               wen    = 1'b1;
               waddr  = cur_ff;
               wdata  = {rd_rank, root_ff};
               raddr  = rd_parent;
               cur_in = rd_parent;
            end
         end
         S_LINK: begin
            res_same_in = (a_ff == root_ff);
            res_root_in = IDX_W'(a_ff);
            state_in    = S_DONE;
            if (kind_ff == KIND_UNION && a_ff != root_ff) begin
               if (sets_ff != '0) begin
                  sets_in = sets_ff - CNT_W'(1);
               end
               wen = 1'b1;
               if (rank_a_ff > rank_root_ff) begin
                  waddr = root_ff;
                  wdata = {rank_root_ff, a_ff};
               end else begin
                  waddr       = a_ff;
                  wdata       = {rank_a_ff, root_ff};
                  res_root_in = IDX_W'(root_ff);
                  if (rank_a_ff == rank_root_ff && 32'(rank_root_ff) < RANK_MAX) begin
                     state_in = S_BUMP;
                  end
               end
            end
         end
         S_BUMP: begin
            wen      = 1'b1;
            waddr    = root_ff;
            wdata    = {rank_root_ff + RANK_W'(1), root_ff};
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               out_same_in  = res_same_ff;
               out_root_in  = res_root_ff;
               out_live_in  = sets_ff;
               out_err_in   = res_err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
